// ===== rtl/farm1_frame_acceptance_assert.svh =====
// Assertion macros used by the FARM-1 receiver checker.
// Needs a clock i_clk and an active-low reset i_rst_n in the using scope.
`ifndef FARM1_FRAME_ACCEPTANCE_ASSERT_SVH
`define FARM1_FRAME_ACCEPTANCE_ASSERT_SVH

// Same-cycle implication.
`define F1FA_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("f1fa check failed");

// Next-cycle implication.
`define F1FA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("f1fa check failed");

`endif

// ===== rtl/f1fa_pkg.sv =====
// Package for the FARM-1 receiver: codes, field layouts and shared types.
// Used by every module of the block; no dependencies.
package f1fa_pkg;

    localparam int unsigned HEADER_OCTETS = 5;
    localparam int unsigned CHECK_OCTETS  = 2;

    localparam int unsigned IN_TDATA_W  = 48;
    localparam int unsigned IN_TUSER_W  = 2;
    localparam int unsigned OUT_TDATA_W = 24;
    localparam int unsigned OUT_TUSER_W = 1;
    localparam int unsigned CFG_IDX_W   = 3;
    localparam int unsigned CFG_DATA_W  = 8;

    // config register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_WIDTH = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RETX_LIMIT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ECF_PRESENT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_UNLOCK       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SETVR_FIRST  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SETVR_SECOND = 3'd5;

    // input function codes
    localparam logic [1:0] FUNC_FRAME  = 2'd0;
    localparam logic [1:0] FUNC_REPORT = 2'd1;
    localparam logic [1:0] FUNC_FREED  = 2'd2;
    localparam logic [1:0] FUNC_RESET  = 2'd3;

    // service types
    localparam logic [1:0] SVC_AD  = 2'd0;
    localparam logic [1:0] SVC_BD  = 2'd1;
    localparam logic [1:0] SVC_BC  = 2'd2;
    localparam logic [1:0] SVC_RSV = 2'd3;

    // FARM states
    localparam logic [1:0] MODE_OPEN    = 2'd0;
    localparam logic [1:0] MODE_WAIT    = 2'd1;
    localparam logic [1:0] MODE_LOCKOUT = 2'd2;

    // event codes
    localparam logic [3:0] EV_NONE       = 4'd0;
    localparam logic [3:0] EV_IN_SEQ     = 4'd1;
    localparam logic [3:0] EV_NO_BUF     = 4'd2;
    localparam logic [3:0] EV_POS_WIN    = 4'd3;
    localparam logic [3:0] EV_NEG_WIN    = 4'd4;
    localparam logic [3:0] EV_LOCKOUT    = 4'd5;
    localparam logic [3:0] EV_BD         = 4'd6;
    localparam logic [3:0] EV_UNLOCK     = 4'd7;
    localparam logic [3:0] EV_SETVR      = 4'd8;
    localparam logic [3:0] EV_BAD_CTRL   = 4'd9;
    localparam logic [3:0] EV_RES_FREED  = 4'd10;
    localparam logic [3:0] EV_REPORT     = 4'd11;

    typedef struct packed {
        logic [7:0] window_width;
        logic       retx_limit;
        logic       ecf_present;
        logic [7:0] unlock_octet;
        logic [7:0] setvr_first;
        logic [7:0] setvr_second;
    } t_cfg;

    typedef struct packed {
        logic [1:0]  func;
        logic [1:0]  service_type;
        logic [7:0]  frame_seq;
        logic        buffer_available;
        logic        resources_free;
        logic [10:0] frame_length;
        logic [7:0]  cmd_first;
        logic [7:0]  cmd_second;
        logic [7:0]  cmd_third;
    } t_item;

    typedef struct packed {
        logic [1:0] mode;
        logic       lockout;
        logic       wait_bit;
        logic       retx;
        logic [1:0] b_count;
        logic [7:0] vr;
    } t_farm;

    typedef struct packed {
        logic [3:0] event_code;
        logic       notice;
        logic       forward_frame;
        logic       drop_frame;
        logic       report_valid;
    } t_verdict;

endpackage

// ===== rtl/f1fa_cfg_regs.sv =====
// Configuration register file of the FARM-1 receiver.
// Depends on f1fa_pkg.
module f1fa_cfg_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [f1fa_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [f1fa_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output f1fa_pkg::t_cfg                o_cfg
);
    import f1fa_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.window_width <= 8'd10;
            r_cfg.retx_limit   <= 1'b1;
            r_cfg.ecf_present  <= 1'b1;
            r_cfg.unlock_octet <= 8'd0;
            r_cfg.setvr_first  <= 8'd130;
            r_cfg.setvr_second <= 8'd0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_WINDOW_WIDTH: r_cfg.window_width <= i_cfg_data;
                CFG_RETX_LIMIT:   r_cfg.retx_limit   <= i_cfg_data[0];
                CFG_ECF_PRESENT:  r_cfg.ecf_present  <= i_cfg_data[0];
                CFG_UNLOCK:       r_cfg.unlock_octet <= i_cfg_data;
                CFG_SETVR_FIRST:  r_cfg.setvr_first  <= i_cfg_data;
                CFG_SETVR_SECOND: r_cfg.setvr_second <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== rtl/f1fa_engine.sv =====
// FARM-1 decision logic: classifies one item and computes next state and verdict.
// Purely combinational; depends on f1fa_pkg.
module f1fa_engine #(
    parameter int unsigned HEADER_OCTETS = f1fa_pkg::HEADER_OCTETS,
    parameter int unsigned CHECK_OCTETS  = f1fa_pkg::CHECK_OCTETS
) (
    input  f1fa_pkg::t_item    i_item,
    input  f1fa_pkg::t_farm    i_farm,
    input  f1fa_pkg::t_cfg     i_cfg,
    output f1fa_pkg::t_farm    o_farm,
    output f1fa_pkg::t_verdict o_verdict
);
    import f1fa_pkg::*;

    localparam logic [10:0] LEN_BASE_NO_ECF = 11'(HEADER_OCTETS);
    localparam logic [10:0] LEN_BASE_ECF    = 11'(HEADER_OCTETS + CHECK_OCTETS);

    logic [7:0]  ahead;
    logic [7:0]  behind;
    logic [7:0]  pos_w;
    logic [7:0]  neg_w;
    logic [10:0] len_base;
    logic        is_unlock;
    logic        is_setvr;
    t_farm       n_farm;
    t_verdict    vd;

    assign ahead     = i_item.frame_seq - i_farm.vr;
    assign behind    = i_farm.vr - i_item.frame_seq;
    assign pos_w     = i_cfg.retx_limit ? {1'b0, i_cfg.window_width[7:1]} : i_cfg.window_width;
    assign neg_w     = i_cfg.retx_limit ? {1'b0, i_cfg.window_width[7:1]} : 8'd0;
    assign len_base  = i_cfg.ecf_present ? LEN_BASE_ECF : LEN_BASE_NO_ECF;
    assign is_unlock = (i_item.frame_length == len_base + 11'd1)
                       && (i_item.cmd_first == i_cfg.unlock_octet);
    assign is_setvr  = (i_item.frame_length == len_base + 11'd3)
                       && (i_item.cmd_first == i_cfg.setvr_first)
                       && (i_item.cmd_second == i_cfg.setvr_second);

    always_comb begin
        n_farm = i_farm;
        vd     = '0;
        case (i_item.func)
            FUNC_FRAME: begin
                case (i_item.service_type)
                    SVC_AD: begin
                        vd.drop_frame = 1'b1;
                        if (i_item.frame_seq == i_farm.vr) begin
                            if (i_item.buffer_available) begin
                                vd.event_code = EV_IN_SEQ;
                                if (i_farm.mode == MODE_OPEN) begin
                                    vd.forward_frame = 1'b1;
                                    vd.drop_frame    = 1'b0;
                                    n_farm.vr        = i_farm.vr + 8'd1;
                                    n_farm.retx      = 1'b0;
                                end else if (i_farm.mode == MODE_WAIT) begin
                                    vd.notice = 1'b1;
                                end
                            end else begin
                                vd.event_code = EV_NO_BUF;
                                if (i_farm.mode == MODE_OPEN) begin
                                    n_farm.retx     = 1'b1;
                                    n_farm.wait_bit = 1'b1;
                                    n_farm.mode     = MODE_WAIT;
                                end
                            end
                        end else if (ahead < pos_w) begin
                            vd.event_code = EV_POS_WIN;
                            if (i_farm.mode == MODE_OPEN) begin
                                n_farm.retx = 1'b1;
                            end
                        end else if ((behind != 8'd0) && (behind <= neg_w)) begin
                            vd.event_code = EV_NEG_WIN;
                        end else begin
                            vd.event_code  = EV_LOCKOUT;
                            n_farm.lockout = 1'b1;
                            n_farm.mode    = MODE_LOCKOUT;
                        end
                    end
                    SVC_BD: begin
                        vd.event_code    = EV_BD;
                        vd.forward_frame = 1'b1;
                        n_farm.b_count   = i_farm.b_count + 2'd1;
                    end
                    SVC_BC: begin
                        vd.drop_frame = 1'b1;
                        if (is_unlock) begin
                            vd.event_code   = EV_UNLOCK;
                            n_farm.b_count  = i_farm.b_count + 2'd1;
                            n_farm.retx     = 1'b0;
                            n_farm.wait_bit = 1'b0;
                            n_farm.lockout  = 1'b0;
                            n_farm.mode     = MODE_OPEN;
                        end else if (is_setvr) begin
                            vd.event_code  = EV_SETVR;
                            n_farm.b_count = i_farm.b_count + 2'd1;
                            if (i_farm.mode == MODE_OPEN || i_farm.mode == MODE_WAIT) begin
                                n_farm.retx     = 1'b0;
                                n_farm.wait_bit = 1'b0;
                                n_farm.vr       = i_item.cmd_third;
                                n_farm.mode     = MODE_OPEN;
                            end
                        end else begin
                            vd.event_code = EV_BAD_CTRL;
                        end
                    end
                    default: begin
                        vd.event_code = EV_BAD_CTRL;
                        vd.drop_frame = 1'b1;
                    end
                endcase
            end
            FUNC_REPORT: begin
                vd.event_code   = EV_REPORT;
                vd.report_valid = 1'b1;
            end
            FUNC_FREED: begin
                if (i_item.resources_free && i_farm.wait_bit) begin
                    vd.event_code   = EV_RES_FREED;
                    n_farm.wait_bit = 1'b0;
                    if (i_farm.mode == MODE_WAIT) begin
                        n_farm.mode = MODE_OPEN;
                    end
                end
            end
            default: begin
                n_farm = '0;
            end
        endcase
    end

    assign o_farm    = n_farm;
    assign o_verdict = vd;

endmodule

// ===== rtl/farm1_frame_acceptance.sv =====
// FARM-1 receiver of the COP-1 protocol. An accepted transaction passes an input
// register, combinational decision logic and an output register, which holds its
// result; one transaction is taken every cycle while the master side does not stall,
// since the FARM state (mode, flags, FARM-B counter, V(R)) is updated as the result
// is registered and is ready for the next item. A stall on the master side backs
// up through the output register, then the input register. Configuration writes
// take effect on the next cycle and are meant to occur while the block is idle.
// Depends on f1fa_pkg, f1fa_cfg_regs and f1fa_engine.
module farm1_frame_acceptance #(
    parameter int unsigned HEADER_OCTETS = f1fa_pkg::HEADER_OCTETS,
    parameter int unsigned CHECK_OCTETS  = f1fa_pkg::CHECK_OCTETS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // slave side
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    // [1:0] service_type, [9:2] frame_seq, [10] buffer_available, [11] resources_free,
    // [22:12] frame_length, [30:23] cmd_first, [38:31] cmd_second, [46:39] cmd_third
    input  logic [f1fa_pkg::IN_TDATA_W-1:0]  i_s_tdata,
    // [1:0] func
    input  logic [f1fa_pkg::IN_TUSER_W-1:0]  i_s_tuser,
    // master side
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    // [3:0] event_code, [4] notice, [5] forward_frame, [6] drop_frame, [8:7] farm_state,
    // [9] lockout_flag, [10] wait_flag, [11] retransmit_flag, [13:12] b_counter,
    // [21:14] expected_seq
    output logic [f1fa_pkg::OUT_TDATA_W-1:0] o_m_tdata,
    // [0] report_valid
    output logic [f1fa_pkg::OUT_TUSER_W-1:0] o_m_tuser,
    // configuration
    input  logic                             i_cfg_we,
    input  logic [f1fa_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [f1fa_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import f1fa_pkg::*;

    t_cfg     cfg;
    t_item    r_item;
    logic     r_item_valid;
    t_farm    r_farm;
    t_farm    n_farm;
    t_verdict verdict;
    logic     r_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_data;
    logic [OUT_TUSER_W-1:0] r_out_user;
    logic     in_accept;
    logic     advance;

    f1fa_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    f1fa_engine #(
        .HEADER_OCTETS (HEADER_OCTETS),
        .CHECK_OCTETS  (CHECK_OCTETS)
    ) u_engine (
        .i_item    (r_item),
        .i_farm    (r_farm),
        .i_cfg     (cfg),
        .o_farm    (n_farm),
        .o_verdict (verdict)
    );

    assign advance    = r_item_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_item_valid || advance;
    assign in_accept  = i_s_tvalid && o_s_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item_valid <= 1'b0;
            r_out_valid  <= 1'b0;
            r_farm       <= '0;
        end else begin
            if (in_accept) begin
                r_item_valid <= 1'b1;
            end else if (advance) begin
                r_item_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_farm      <= n_farm;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_item.func             <= i_s_tuser[1:0];
            r_item.service_type     <= i_s_tdata[1:0];
            r_item.frame_seq        <= i_s_tdata[9:2];
            r_item.buffer_available <= i_s_tdata[10];
            r_item.resources_free   <= i_s_tdata[11];
            r_item.frame_length     <= i_s_tdata[22:12];
            r_item.cmd_first        <= i_s_tdata[30:23];
            r_item.cmd_second       <= i_s_tdata[38:31];
            r_item.cmd_third        <= i_s_tdata[46:39];
        end
        if (advance) begin
            r_out_data <= {2'b00, n_farm.vr, n_farm.b_count, n_farm.retx, n_farm.wait_bit,
                           n_farm.lockout, n_farm.mode, verdict.drop_frame,
                           verdict.forward_frame, verdict.notice, verdict.event_code};
            r_out_user <= verdict.report_valid;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_user;

endmodule

// ===== rtl/f1fa_checker.sv =====
// Port-level checks of the FARM-1 receiver, bound to the top level.
// Depends on f1fa_pkg and farm1_frame_acceptance_assert.svh.
`include "farm1_frame_acceptance_assert.svh"

module f1fa_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             o_m_tvalid,
    input logic                             i_m_tready,
    input logic [f1fa_pkg::OUT_TDATA_W-1:0] o_m_tdata,
    input logic [f1fa_pkg::OUT_TUSER_W-1:0] o_m_tuser
);
    import f1fa_pkg::*;

    // result held while stalled
    `F1FA_ASSERT_NEXT(a_hold, o_m_tvalid && !i_m_tready, o_m_tvalid && $stable(o_m_tdata))
    // a frame is never both forwarded and dropped
    `F1FA_ASSERT_NOW(a_fwd_drop, o_m_tvalid, !(o_m_tdata[5] && o_m_tdata[6]))
    // a report snapshot always carries E11
    `F1FA_ASSERT_NOW(a_report, o_m_tvalid && o_m_tuser[0], o_m_tdata[3:0] == EV_REPORT)
    // lockout flag tracks the lockout state
    `F1FA_ASSERT_NOW(a_lockout, o_m_tvalid, o_m_tdata[9] == (o_m_tdata[8:7] == MODE_LOCKOUT))

endmodule

bind farm1_frame_acceptance f1fa_checker u_f1fa_checker (.*);

// ===== tb/farm1_frame_acceptance_test.sv =====
// Self-checking testbench for the FARM-1 receiver farm1_frame_acceptance.
// Streams directed and random frame events and compares each result with a predictor.
// Depends on f1fa_pkg and the RTL of the block only.
`timescale 1ns / 100ps

module farm1_frame_acceptance_test;
    import f1fa_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int unsigned PHASE_ITEMS  = 250;
    localparam int unsigned PHASE_COUNT  = 7;

    typedef struct packed {
        logic [3:0] ev;
        logic       notice;
        logic       fwd;
        logic       drop;
        logic [1:0] mode;
        logic       lockout;
        logic       wflag;
        logic       retx;
        logic [1:0] bcnt;
        logic [7:0] vr;
        logic       report;
    } t_farm_result;

    class farm_scoreboard;
        t_cfg         cfg;
        t_farm        farm;
        t_farm_result pending[$];
        int           errors;

        function new();
            cfg.window_width = 8'd10;
            cfg.retx_limit   = 1'b1;
            cfg.ecf_present  = 1'b1;
            cfg.unlock_octet = 8'd0;
            cfg.setvr_first  = 8'd130;
            cfg.setvr_second = 8'd0;
            farm             = '0;
            errors           = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] val);
            case (idx)
                CFG_WINDOW_WIDTH: cfg.window_width = val;
                CFG_RETX_LIMIT:   cfg.retx_limit   = val[0];
                CFG_ECF_PRESENT:  cfg.ecf_present  = val[0];
                CFG_UNLOCK:       cfg.unlock_octet = val;
                CFG_SETVR_FIRST:  cfg.setvr_first  = val;
                CFG_SETVR_SECOND: cfg.setvr_second = val;
                default: ;
            endcase
        endfunction

        function logic [7:0] pos_width();
            return cfg.retx_limit ? (cfg.window_width >> 1) : cfg.window_width;
        endfunction

        function logic [7:0] neg_width();
            return cfg.retx_limit ? (cfg.window_width >> 1) : 8'd0;
        endfunction

        function logic [10:0] ctrl_base();
            return 11'(HEADER_OCTETS) + (cfg.ecf_present ? 11'(CHECK_OCTETS) : 11'd0);
        endfunction

        // advances the FARM copy by one accepted transaction and queues its result
        function void note_item(t_item it);
            t_farm_result r;
            logic [7:0]   ahead;
            logic [7:0]   behind;
            r = '0;
            ahead  = it.frame_seq - farm.vr;
            behind = farm.vr - it.frame_seq;
            case (it.func)
                FUNC_FRAME: begin
                    case (it.service_type)
                        SVC_AD: begin
                            if (it.frame_seq == farm.vr) begin
                                if (it.buffer_available) begin
                                    r.ev = EV_IN_SEQ;
                                    if (farm.mode == MODE_OPEN) begin
                                        r.fwd     = 1'b1;
                                        farm.vr   = farm.vr + 8'd1;
                                        farm.retx = 1'b0;
                                    end else if (farm.mode == MODE_WAIT) begin
                                        r.notice = 1'b1;
                                        r.drop   = 1'b1;
                                    end else begin
                                        r.drop = 1'b1;
                                    end
                                end else begin
                                    r.ev   = EV_NO_BUF;
                                    r.drop = 1'b1;
                                    if (farm.mode == MODE_OPEN) begin
                                        farm.retx     = 1'b1;
                                        farm.wait_bit = 1'b1;
                                        farm.mode     = MODE_WAIT;
                                    end
                                end
                            end else begin
                                r.drop = 1'b1;
                                if (ahead < pos_width()) begin
                                    r.ev = EV_POS_WIN;
                                    if (farm.mode == MODE_OPEN)
                                        farm.retx = 1'b1;
                                end else if (behind >= 8'd1 && behind <= neg_width()) begin
                                    r.ev = EV_NEG_WIN;
                                end else begin
                                    r.ev         = EV_LOCKOUT;
                                    farm.lockout = 1'b1;
                                    farm.mode    = MODE_LOCKOUT;
                                end
                            end
                        end
                        SVC_BD: begin
                            r.ev         = EV_BD;
                            r.fwd        = 1'b1;
                            farm.b_count = farm.b_count + 2'd1;
                        end
                        SVC_BC: begin
                            r.drop = 1'b1;
                            if (it.frame_length == ctrl_base() + 11'd1 &&
                                it.cmd_first == cfg.unlock_octet) begin
                                r.ev          = EV_UNLOCK;
                                farm.b_count  = farm.b_count + 2'd1;
                                farm.retx     = 1'b0;
                                farm.wait_bit = 1'b0;
                                farm.lockout  = 1'b0;
                                farm.mode     = MODE_OPEN;
                            end else if (it.frame_length == ctrl_base() + 11'd3 &&
                                         it.cmd_first == cfg.setvr_first &&
                                         it.cmd_second == cfg.setvr_second) begin
                                r.ev         = EV_SETVR;
                                farm.b_count = farm.b_count + 2'd1;
                                if (farm.mode == MODE_OPEN || farm.mode == MODE_WAIT) begin
                                    farm.retx     = 1'b0;
                                    farm.wait_bit = 1'b0;
                                    farm.vr       = it.cmd_third;
                                    farm.mode     = MODE_OPEN;
                                end
                            end else begin
                                r.ev = EV_BAD_CTRL;
                            end
                        end
                        default: begin
                            r.ev   = EV_BAD_CTRL;
                            r.drop = 1'b1;
                        end
                    endcase
                end
                FUNC_REPORT: begin
                    r.ev     = EV_REPORT;
                    r.report = 1'b1;
                end
                FUNC_FREED: begin
                    if (it.resources_free && farm.wait_bit) begin
                        r.ev          = EV_RES_FREED;
                        farm.wait_bit = 1'b0;
                        if (farm.mode == MODE_WAIT)
                            farm.mode = MODE_OPEN;
                    end
                end
                default: farm = '0;
            endcase
            r.mode    = farm.mode;
            r.lockout = farm.lockout;
            r.wflag   = farm.wait_bit;
            r.retx    = farm.retx;
            r.bcnt    = farm.b_count;
            r.vr      = farm.vr;
            pending.push_back(r);
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned got);
            if (want != got) begin
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_result(logic [OUT_TDATA_W-1:0] d, logic [OUT_TUSER_W-1:0] u);
            t_farm_result want;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual tdata %h tuser %h",
                         $time, d, u);
                errors++;
                return;
            end
            want = pending.pop_front();
            compare_field("event_code", want.ev, d[3:0]);
            compare_field("notice", want.notice, d[4]);
            compare_field("forward_frame", want.fwd, d[5]);
            compare_field("drop_frame", want.drop, d[6]);
            compare_field("farm_state", want.mode, d[8:7]);
            compare_field("lockout_flag", want.lockout, d[9]);
            compare_field("wait_flag", want.wflag, d[10]);
            compare_field("retransmit_flag", want.retx, d[11]);
            compare_field("b_counter", want.bcnt, d[13:12]);
            compare_field("expected_seq", want.vr, d[21:14]);
            compare_field("report_valid", want.report, u[0]);
        endfunction
    endclass

    logic                   i_clk      = 1'b0;
    logic                   i_rst_n    = 1'b0;
    logic                   i_s_tvalid = 1'b0;
    logic                   o_s_tready;
    logic [IN_TDATA_W-1:0]  i_s_tdata  = '0;
    logic [IN_TUSER_W-1:0]  i_s_tuser  = '0;
    logic                   o_m_tvalid;
    logic                   i_m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] o_m_tdata;
    logic [OUT_TUSER_W-1:0] o_m_tuser;
    logic                   i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_idx  = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data = '0;

    farm_scoreboard sb = new();
    bit             calm = 1'b0;
    int unsigned    cycle_count = 0;

    farm1_frame_acceptance DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready)
            sb.check_result(o_m_tdata, o_m_tuser);
    end

    // master side backpressure
    initial begin
        forever begin
            if (!calm && $urandom_range(0, 3) == 0) begin
                i_m_tready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge i_clk);
            end
            i_m_tready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
    end

    function automatic t_item frame_item(logic [1:0] func, logic [1:0] stype,
                                         logic [7:0] ns, logic bufa, logic res,
                                         logic [10:0] len, logic [7:0] c1,
                                         logic [7:0] c2, logic [7:0] c3);
        t_item it;
        it.func             = func;
        it.service_type     = stype;
        it.frame_seq        = ns;
        it.buffer_available = bufa;
        it.resources_free   = res;
        it.frame_length     = len;
        it.cmd_first        = c1;
        it.cmd_second       = c2;
        it.cmd_third        = c3;
        return it;
    endfunction

    // mostly in-window AD traffic and well-formed commands, with noise mixed in
    function automatic t_item random_item();
        t_item       it;
        int unsigned k;
        int unsigned s;
        it.func             = FUNC_FRAME;
        it.service_type     = 2'($urandom_range(0, 3));
        it.frame_seq        = 8'($urandom);
        it.buffer_available = ($urandom_range(0, 99) < 85);
        it.resources_free   = ($urandom_range(0, 99) < 75);
        it.frame_length     = ($urandom_range(0, 9) == 0) ? 11'd1024
                                                          : 11'($urandom_range(0, 1023));
        it.cmd_first        = 8'($urandom);
        it.cmd_second       = 8'($urandom);
        it.cmd_third        = 8'($urandom);
        k = $urandom_range(0, 99);
        if (k < 45) begin
            it.service_type = SVC_AD;
            s = $urandom_range(0, 99);
            if (s < 55)
                it.frame_seq = sb.farm.vr;
            else if (s < 67)
                it.frame_seq = sb.farm.vr + 8'($urandom_range(1, sb.pos_width()));
            else if (s < 77)
                it.frame_seq = sb.farm.vr - 8'($urandom_range(1, sb.neg_width() + 1));
        end else if (k < 55) begin
            it.service_type = SVC_BD;
        end else if (k < 70) begin
            it.service_type = SVC_BC;
            s = $urandom_range(0, 99);
            if (s < 40) begin
                it.frame_length = sb.ctrl_base() + 11'd1;
                it.cmd_first    = sb.cfg.unlock_octet;
            end else if (s < 80) begin
                it.frame_length = sb.ctrl_base() + 11'd3;
                it.cmd_first    = sb.cfg.setvr_first;
                it.cmd_second   = sb.cfg.setvr_second;
            end else if (s < 90) begin
                it.frame_length = sb.ctrl_base() + 11'($urandom_range(0, 4));
            end
        end else if (k < 74) begin
            it.service_type = SVC_RSV;
        end else if (k < 85) begin
            it.func = FUNC_REPORT;
        end else if (k < 97) begin
            it.func = FUNC_FREED;
        end else begin
            it.func = FUNC_RESET;
        end
        return it;
    endfunction

    task automatic send_item(input t_item it);
        if (!calm && $urandom_range(0, 4) == 0) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= it.func;
        i_s_tdata  <= {1'b0, it.cmd_third, it.cmd_second, it.cmd_first, it.frame_length,
                       it.resources_free, it.buffer_available, it.frame_seq,
                       it.service_type};
        do @(posedge i_clk); while (!o_s_tready);
        sb.note_item(it);
    endtask

    task automatic drain();
        i_s_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        sb.set_reg(idx, val);
    endtask

    task automatic load_settings(input logic [7:0] w, input logic retx, input logic ecf,
                                 input logic [7:0] unl, input logic [7:0] sv1,
                                 input logic [7:0] sv2);
        write_reg(CFG_WINDOW_WIDTH, w);
        write_reg(CFG_RETX_LIMIT, {7'd0, retx});
        write_reg(CFG_ECF_PRESENT, {7'd0, ecf});
        write_reg(CFG_UNLOCK, unl);
        write_reg(CFG_SETVR_FIRST, sv1);
        write_reg(CFG_SETVR_SECOND, sv2);
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        t_item       dir_items[$];
        logic [7:0]  w;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed walk under reset settings: W 10, split window, ECF on
        dir_items.push_back(frame_item(FUNC_REPORT, SVC_AD, 8'd0, 1'b0, 1'b0, 11'd0,
                                       8'd0, 8'd0, 8'd0));
        dir_items.push_back(frame_item(FUNC_FRAME, SVC_AD, 8'd0, 1'b1, 1'b0, 11'd20,
                                       8'd1, 8'd2, 8'd3));
        dir_items.push_back(frame_item(FUNC_FRAME, SVC_AD, 8'd1, 1'b0, 1'b0, 11'd20,
                                       8'd0, 8'd0, 8'd0));
        dir_items.push_back(frame_item(FUNC_FRAME, SVC_AD, 8'd1, 1'b1, 1'b0, 11'd20,
                                       8'd0, 8'd0, 8'd0));
        dir_items.push_back(frame_item(FUNC_FREED, SVC_AD, 8'd0, 1'b0, 1'b0, 11'd0,
                                       8'd0, 8'd0, 8'd0));
        dir_items.push_back(frame_item(FUNC_FREED, SVC_AD, 8'd0, 1'b0, 1'b1, 11'd0,
                                       8'd0, 8'd0, 8'd0));
        dir_items.push_back(frame_item(FUNC_FRAME, SVC_AD, 8'd5, 1'b1, 1'b0, 11'd20,
                                       8'd0, 8'd0, 8'd0));
        dir_items.push_back(frame_item(FUNC_FRAME, SVC_AD, 8'd0, 1'b1, 1'b0, 11'd20,
                                       8'd0, 8'd0, 8'd0));
        dir_items.push_back(frame_item(FUNC_FRAME, SVC_AD, 8'd6, 1'b1, 1'b0, 11'd20,
                                       8'd0, 8'd0, 8'd0));
        dir_items.push_back(frame_item(FUNC_FRAME, SVC_AD, 8'd1, 1'b1, 1'b0, 11'd20,
                                       8'd0, 8'd0, 8'd0));
        dir_items.push_back(frame_item(FUNC_FRAME, SVC_AD, 8'd1, 1'b0, 1'b0, 11'd20,
                                       8'd0, 8'd0, 8'd0));
        dir_items.push_back(frame_item(FUNC_FRAME, SVC_BD, 8'd77, 1'b0, 1'b0, 11'd30,
                                       8'd0, 8'd0, 8'd0));
        dir_items.push_back(frame_item(FUNC_FRAME, SVC_BC, 8'd0, 1'b0, 1'b0, 11'd10,
                                       8'd130, 8'd0, 8'd200));
        dir_items.push_back(frame_item(FUNC_FRAME, SVC_BC, 8'd0, 1'b0, 1'b0, 11'd8,
                                       8'd0, 8'd0, 8'd0));
        dir_items.push_back(frame_item(FUNC_FRAME, SVC_BC, 8'd0, 1'b0, 1'b0, 11'd10,
                                       8'd130, 8'd0, 8'd255));
        dir_items.push_back(frame_item(FUNC_FRAME, SVC_AD, 8'd255, 1'b1, 1'b0, 11'd20,
                                       8'd0, 8'd0, 8'd0));
        dir_items.push_back(frame_item(FUNC_FRAME, SVC_BC, 8'd0, 1'b0, 1'b0, 11'd9,
                                       8'd0, 8'd0, 8'd0));
        dir_items.push_back(frame_item(FUNC_FRAME, SVC_BC, 8'd0, 1'b0, 1'b0, 11'd8,
                                       8'd1, 8'd0, 8'd0));
        dir_items.push_back(frame_item(FUNC_FRAME, SVC_RSV, 8'd0, 1'b1, 1'b1, 11'd8,
                                       8'd0, 8'd0, 8'd0));
        dir_items.push_back(frame_item(FUNC_FRAME, SVC_BD, 8'd0, 1'b0, 1'b0, 11'd8,
                                       8'd0, 8'd0, 8'd0));
        dir_items.push_back(frame_item(FUNC_FREED, SVC_AD, 8'd0, 1'b0, 1'b1, 11'd0,
                                       8'd0, 8'd0, 8'd0));
        dir_items.push_back(frame_item(FUNC_RESET, SVC_AD, 8'd0, 1'b0, 1'b0, 11'd0,
                                       8'd0, 8'd0, 8'd0));
        dir_items.push_back(frame_item(FUNC_FRAME, SVC_AD, 8'd255, 1'b1, 1'b1, 11'd1024,
                                       8'd255, 8'd255, 8'd255));
        dir_items.push_back(frame_item(FUNC_FRAME, SVC_AD, 8'd0, 1'b0, 1'b0, 11'd0,
                                       8'd0, 8'd0, 8'd0));
        dir_items.push_back(frame_item(FUNC_FRAME, SVC_BC, 8'd0, 1'b0, 1'b0, 11'd0,
                                       8'd0, 8'd0, 8'd0));
        dir_items.push_back(frame_item(FUNC_FREED, SVC_AD, 8'd0, 1'b0, 1'b1, 11'd0,
                                       8'd0, 8'd0, 8'd0));
        foreach (dir_items[i])
            send_item(dir_items[i]);

        for (int p = 0; p < PHASE_COUNT; p++) begin
            drain();
            w = 8'($urandom_range(1, 127) * 2);
            case (p)
                0: load_settings(8'd2, 1'b1, 1'b0, 8'd0, 8'd0, 8'd0);
                1: load_settings(8'd254, 1'b0, 1'b1, 8'd255, 8'd255, 8'd255);
                2: load_settings(8'd254, 1'b1, 1'b0, 8'($urandom), 8'($urandom),
                                 8'($urandom));
                3: load_settings(8'd2, 1'b0, 1'b1, 8'($urandom), 8'($urandom),
                                 8'($urandom));
                default: load_settings(w, 1'($urandom), 1'($urandom), 8'($urandom),
                                       8'($urandom), 8'($urandom));
            endcase
            calm = (p == PHASE_COUNT - 1);
            repeat (PHASE_ITEMS) send_item(random_item());
        end

        drain();
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ===== farm1_frame_acceptance.f =====
+incdir+rtl
rtl/f1fa_pkg.sv
rtl/f1fa_cfg_regs.sv
rtl/f1fa_engine.sv
rtl/farm1_frame_acceptance.sv
rtl/f1fa_checker.sv
tb/farm1_frame_acceptance_test.sv
